// ----- sv/foot_contact_classifier_top_macros.svh -----
// Assertion macros shared by the checker of the foot contact classifier.
// Needs nothing else; each macro is a clocked concurrent assertion with reset disable.
`ifndef FOOT_CONTACT_CLASSIFIER_TOP_MACROS_SVH
`define FOOT_CONTACT_CLASSIFIER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("foot contact classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("foot contact classifier check failed");

`endif

// ----- sv/fcc_pkg.sv -----
// Shared types, sizes and codes of the foot contact classifier.
// Used by every RTL module but fcc_ram, and by the checker; depends on nothing.
package fcc_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int FORCE_W = 24;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 17;
    localparam int ENTRY_W = TIME_W + 2 * FORCE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STATUS_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WLEN   = 2'd2;

    localparam logic [GAIN_W-1:0]         GAIN_RESET   = 17'd32768;
    localparam logic signed [FORCE_W-1:0] THRESH_RESET = 24'sd25600;
    localparam logic [TIME_W-1:0]         WLEN_RESET   = 32'd200000;

    typedef enum logic [STATUS_W-1:0] {
        ST_AIR      = 3'd0,
        ST_LEFT     = 3'd1,
        ST_RIGHT    = 3'd2,
        ST_BOTH     = 3'd3,
        ST_UNSTABLE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_ACC_L,
        S_MUL_R,
        S_ACC_R,
        S_WRITE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic mul_en;
        logic sel_right;
    } filt_ctrl_t;

    // Ring index plus offset, wrapped once into the window depth.
    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(WINDOW_DEPTH))
        begin
            s = s - (CNT_W + 1)'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/fcc_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing; holds the timestamped window of the classifier.
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fcc_filter_unit.sv -----
// Shared multiply and accumulate unit of the two low-pass filters.
// Depends on fcc_pkg; one multiply step and one saturating add step per foot.
module fcc_filter_unit (
    input  logic                                clk,
    input  fcc_pkg::filt_ctrl_t                 ctrl,
    input  logic [fcc_pkg::GAIN_W-1:0]          gain,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  left_x,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  right_x,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  left_prev,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  right_prev,
    output logic signed [fcc_pkg::FORCE_W-1:0]  y
);
    import fcc_pkg::*;

    localparam int PROD_W = GAIN_W + FORCE_W + 2;
    localparam int SUM_W  = FORCE_W + 4;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(8388608);

    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] prev;
    logic signed [FORCE_W:0]   diff;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [SUM_W-1:0]   sum;

    assign x      = ctrl.sel_right ? right_x : left_x;
    assign prev   = ctrl.sel_right ? right_prev : left_prev;
    assign diff   = {x[FORCE_W-1], x} - {prev[FORCE_W-1], prev};
    assign gain_s = {1'b0, gain};

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.mul_en)
        begin
            prod_next = gain_s * diff;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod_sh = prod_reg >>> 16;
    assign sum = {{(SUM_W - FORCE_W){prev[FORCE_W-1]}}, prev}
               + {prod_sh[SUM_W-2], prod_sh[SUM_W-2:0]};

    always_comb
    begin
        if (sum > SAT_MAX)
        begin
            y = SAT_MAX[FORCE_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            y = SAT_MIN[FORCE_W-1:0];
        end
        else
        begin
            y = sum[FORCE_W-1:0];
        end
    end

endmodule

// ----- sv/fcc_seq.sv -----
// Sequencer of the classifier: filter steps, window write, scan, decision and aging.
// Depends on fcc_pkg, fcc_filter_unit and fcc_ram.
module fcc_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  left_force,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  right_force,
    input  logic [fcc_pkg::TIME_W-1:0]          sample_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fcc_pkg::STATUS_W-1:0]        contact_status,
    input  logic [fcc_pkg::GAIN_W-1:0]          gain,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  threshold,
    input  logic [fcc_pkg::TIME_W-1:0]          wlen
);
    import fcc_pkg::*;

    seq_state_t state_reg, state_next;

    logic signed [FORCE_W-1:0] lx_reg, lx_next;
    logic signed [FORCE_W-1:0] rx_reg, rx_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic signed [FORCE_W-1:0] lf_reg, lf_next;
    logic signed [FORCE_W-1:0] rf_reg, rf_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      scan_vld_reg, scan_vld_next;
    logic                      l_hi_reg, l_hi_next;
    logic                      r_hi_reg, r_hi_next;
    logic                      l_lo_reg, l_lo_next;
    logic                      r_lo_reg, r_lo_next;
    status_t                   status_reg, status_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   out_status_reg, out_status_next;

    filt_ctrl_t                filt_ctrl;
    logic signed [FORCE_W-1:0] filt_y;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENTRY_W-1:0]        wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]        rd_data;
    logic [TIME_W-1:0]         rd_stamp;
    logic signed [FORCE_W-1:0] rd_left;
    logic signed [FORCE_W-1:0] rd_right;
    logic [TIME_W-1:0]         age;
    logic                      out_free;

    assign rd_stamp = rd_data[ENTRY_W-1 -: TIME_W];
    assign rd_left  = rd_data[2*FORCE_W-1 -: FORCE_W];
    assign rd_right = rd_data[FORCE_W-1:0];
    assign age      = now_reg - rd_stamp;
    assign out_free = !out_valid_reg || !out_stall;

    fcc_filter_unit u_filter (
        .clk        (clk),
        .ctrl       (filt_ctrl),
        .gain       (gain),
        .left_x     (lx_reg),
        .right_x    (rx_reg),
        .left_prev  (lf_reg),
        .right_prev (rf_reg),
        .y          (filt_y)
    );

    fcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_MUL_L;
            S_MUL_L:     state_next = S_ACC_L;
            S_ACC_L:     state_next = S_MUL_R;
            S_MUL_R:     state_next = S_ACC_R;
            S_ACC_R:     state_next = S_WRITE;
            S_WRITE:     state_next = S_SCAN;
            S_SCAN:      if (idx_reg + CNT_W'(1) == count_reg) state_next = S_SCAN_END;
            S_SCAN_END:  state_next = S_DECIDE;
            S_DECIDE:    state_next = S_PRUNE_RD;
            S_PRUNE_RD:  state_next = (count_reg == '0) ? S_OUT : S_PRUNE_CHK;
            S_PRUNE_CHK: state_next = (age > wlen) ? S_PRUNE_RD : S_OUT;
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lx_next         = lx_reg;
        rx_next         = rx_reg;
        now_next        = now_reg;
        lf_next         = lf_reg;
        rf_next         = rf_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        scan_vld_next   = 1'b0;
        l_hi_next       = l_hi_reg;
        r_hi_next       = r_hi_reg;
        l_lo_next       = l_lo_reg;
        r_lo_next       = r_lo_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = {now_reg, lf_reg, rf_reg};
        rd_addr         = head_reg;
        in_stall        = (state_reg != S_IDLE);
        filt_ctrl.mul_en    = state_reg inside {S_MUL_L, S_MUL_R};
        filt_ctrl.sel_right = state_reg inside {S_MUL_R, S_ACC_R};

        if (scan_vld_reg)
        begin
            if (rd_left < threshold)  l_hi_next = 1'b0;
            if (rd_left > threshold)  l_lo_next = 1'b0;
            if (rd_right < threshold) r_hi_next = 1'b0;
            if (rd_right > threshold) r_lo_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lx_next  = left_force;
                    rx_next  = right_force;
                    now_next = sample_time;
                end
            end
            S_ACC_L:
            begin
                lf_next = filt_y;
            end
            S_ACC_R:
            begin
                rf_next = filt_y;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                if (count_reg == CNT_W'(WINDOW_DEPTH))
                begin
                    wr_addr   = head_reg;
                    head_next = wrap_add(head_reg, CNT_W'(1));
                end
                else
                begin
                    wr_addr    = wrap_add(head_reg, count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
                idx_next  = '0;
                l_hi_next = 1'b1;
                r_hi_next = 1'b1;
                l_lo_next = 1'b1;
                r_lo_next = 1'b1;
            end
            S_SCAN:
            begin
                rd_addr       = wrap_add(head_reg, idx_reg);
                idx_next      = idx_reg + CNT_W'(1);
                scan_vld_next = 1'b1;
            end
            S_DECIDE:
            begin
                if (l_hi_reg && r_hi_reg)
                begin
                    status_next = ST_BOTH;
                end
                else if (l_lo_reg && r_lo_reg)
                begin
                    status_next = ST_AIR;
                end
                else if (l_hi_reg)
                begin
                    status_next = ST_LEFT;
                end
                else if (r_hi_reg)
                begin
                    status_next = ST_RIGHT;
                end
                else
                begin
                    status_next = ST_UNSTABLE;
                end
            end
            S_PRUNE_CHK:
            begin
                if (age > wlen)
                begin
                    head_next  = wrap_add(head_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lf_reg         <= '0;
            rf_reg         <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            scan_vld_reg   <= 1'b0;
            status_reg     <= ST_AIR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lf_reg         <= lf_next;
            rf_reg         <= rf_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            scan_vld_reg   <= scan_vld_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lx_reg         <= lx_next;
        rx_reg         <= rx_next;
        now_reg        <= now_next;
        l_hi_reg       <= l_hi_next;
        r_hi_reg       <= r_hi_next;
        l_lo_reg       <= l_lo_next;
        r_lo_reg       <= r_lo_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign contact_status = out_status_reg;

endmodule

// ----- sv/foot_contact_classifier_top.sv -----
// Foot contact classifier: low-pass filtered foot forces judged over a time window.
// Usage: an item on the input channel carries both forces and a microsecond timestamp.
// It is accepted at a clock edge with in_valid high and in_stall low, and each item
// yields one contact_status item on the output channel, taken when out_valid is high
// and out_stall is low. Configuration is written through cfg_valid/cfg_ready with
// cfg_index 0 gain, 1 threshold, 2 window length; cfg_ready is always high.
// in_stall rises at acceptance and falls when the result appears, so the block takes no new
// item before it is through with the last one. Each item runs through the filter steps of
// both feet, the window write, a scan of every held entry, the decision and the aging of
// old entries, so its time grows with the entries held and aged out; it is set by the
// window RAM, whose single read port is scanned one entry per cycle, and by the shared
// filter multiplier, used once per foot. in_stall stays high while an item is worked on.
// The result sits in an output register; if the receiver stalls, a finished result
// holds the sequencer until that register frees, and a stalled result does not change.
// Reset clears the filter memories, empties the window and restores the register
// defaults; no clearing pass is needed since only held entries are ever read.
// Depends on fcc_pkg and fcc_seq.
module foot_contact_classifier_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  left_force,
    input  logic signed [fcc_pkg::FORCE_W-1:0]  right_force,
    input  logic [fcc_pkg::TIME_W-1:0]          sample_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fcc_pkg::STATUS_W-1:0]        contact_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fcc_pkg::*;

    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic signed [FORCE_W-1:0] thresh_reg, thresh_next;
    logic [TIME_W-1:0]         wlen_reg, wlen_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gain_next   = gain_reg;
        thresh_next = thresh_reg;
        wlen_next   = wlen_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN:   gain_next   = cfg_data[GAIN_W-1:0];
                REG_THRESH: thresh_next = cfg_data[FORCE_W-1:0];
                REG_WLEN:   wlen_next   = cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            thresh_reg <= THRESH_RESET;
            wlen_reg   <= WLEN_RESET;
        end
        else
        begin
            gain_reg   <= gain_next;
            thresh_reg <= thresh_next;
            wlen_reg   <= wlen_next;
        end
    end

    fcc_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_force     (left_force),
        .right_force    (right_force),
        .sample_time    (sample_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .contact_status (contact_status),
        .gain           (gain_reg),
        .threshold      (thresh_reg),
        .wlen           (wlen_reg)
    );

endmodule

// ----- sv/fcc_checker.sv -----
// Port-level checker of the foot contact classifier and its bind to the top level.
// Depends on fcc_pkg and on the assertion macros header.
`include "foot_contact_classifier_top_macros.svh"

module fcc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [fcc_pkg::STATUS_W-1:0]        contact_status
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // An accepted item keeps the block busy for the following cycle.
    `FCC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall)

    // No result can appear in the cycle right after an item is accepted.
    `FCC_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_acc, !$rose(out_valid))

    // A new result is only produced while the input side was held off.
    `FCC_ASSERT_SAME(a_result_while_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A stalled result stays valid and unchanged.
    `FCC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(contact_status))

endmodule

bind foot_contact_classifier_top fcc_checker u_fcc_checker (.*);
